// ===== rtl/swlm_pkg.sv =====
// Shared types and constants for the stopwatch with lap memory.
package swlm_pkg;

  // Default number of lap slots in the ring.
  localparam int LAP_SLOTS_DEF = 8;

  // Field widths fixed by the interface.
  localparam int FUNC_W = 2;
  localparam int SLOT_W = 3;
  localparam int MIN_W  = 16;
  localparam int SEC_W  = 6;
  localparam int MS_W   = 10;
  localparam int CNT_W  = 32;
  localparam int DBC_W  = 16;
  localparam int TOT_W  = 16;
  localparam int PRE_W  = 4;

  // Counter limits: ticks per millisecond, millis per second, seconds per minute.
  localparam logic [PRE_W-1:0] TICK_TOP = 4'd9;
  localparam logic [MS_W-1:0]  MS_TOP   = 10'd999;
  localparam logic [SEC_W-1:0] SEC_TOP  = 6'd59;

  // Debounce window after reset.
  localparam logic [DBC_W-1:0] DEBOUNCE_RST = 16'd200;

  // Request function codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_PRESS = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  // One stored lap.
  typedef struct packed {
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
    logic [MS_W-1:0]  millis;
  } lap_entry_t;

endpackage

// ===== rtl/swlm_lap_mem.sv =====
// Lap slot memory: synchronous RAM with per-slot valid bits and registered read.
module swlm_lap_mem
  import swlm_pkg::*;
#(
  parameter int LAP_SLOTS = LAP_SLOTS_DEF,
  parameter int AW        = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  // write port
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  lap_entry_t       wr_data,
  // read port: rd_en advances the read register, rd_req marks a real lookup
  input  logic             rd_en,
  input  logic             rd_req,
  input  logic [AW-1:0]    rd_addr,
  output lap_entry_t       rd_data
);

  lap_entry_t             mem_q [LAP_SLOTS];
  logic [LAP_SLOTS-1:0]   slot_vld_r;
  lap_entry_t             rd_data_r;
  logic                   rd_hit_r;

  // Storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // Registered read; no reset on payload
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_q[rd_addr];
    end
  end

  // Valid bits stand in for the cleared contents after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      rd_hit_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        slot_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= rd_req && slot_vld_r[rd_addr];
      end
    end
  end

  // Never-written slots and non-read requests read as zero
  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

// ===== rtl/stopwatch_with_lap_memory_unit.sv =====
// Stopwatch with lap memory: top level.
// Takes one request per cycle unless stalled (tick, button press, lap read)
// and returns one result per request, in the cycle after acceptance; the
// result sits in an output register, and a new request enters whenever that
// register is empty or being taken. The lap ring lives in a single-port-write
// RAM with a registered read; a valid bit per slot, cleared by reset, makes
// never-written slots read as zero, so no clearing pass follows reset. Lap
// reads beyond LAP_SLOTS return zero. The user must write the debounce window
// via cfg_we/cfg_wdata only while idle; the block does not enforce it.
module stopwatch_with_lap_memory_unit
  import swlm_pkg::*;
#(
  parameter int LAP_SLOTS = LAP_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [SLOT_W-1:0] in_slot,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_running,
  output logic [MIN_W-1:0]  out_minutes_now,
  output logic [SEC_W-1:0]  out_seconds_now,
  output logic [MS_W-1:0]   out_millis_now,
  output logic              out_lap_stored,
  output logic [SLOT_W-1:0] out_stored_slot,
  output logic [TOT_W-1:0]  out_lap_total,
  output logic [SLOT_W-1:0] out_next_slot,
  output logic [MIN_W-1:0]  out_read_minutes,
  output logic [SEC_W-1:0]  out_read_seconds,
  output logic [MS_W-1:0]   out_read_millis,
  // configuration
  input  logic              cfg_we,
  input  logic [DBC_W-1:0]  cfg_wdata
);

  localparam int AW = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;

  // Architectural state
  logic [DBC_W-1:0] debounce_r;
  logic [CNT_W-1:0] free_ms_r,    free_ms_nxt;
  logic [PRE_W-1:0] prescale_r,   prescale_nxt;
  logic [PRE_W-1:0] tenth_r,      tenth_nxt;
  logic [MS_W-1:0]  ms_r,         ms_nxt;
  logic [SEC_W-1:0] sec_r,        sec_nxt;
  logic [MIN_W-1:0] min_r,        min_nxt;
  logic             running_r,    running_nxt;
  logic [CNT_W-1:0] last_press_r, last_press_nxt;
  logic [AW-1:0]    wslot_r,      wslot_nxt;
  logic [TOT_W-1:0] lap_total_r,  lap_total_nxt;

  // Output register
  logic              out_valid_r;
  logic              out_stored_r;
  logic [SLOT_W-1:0] out_stored_slot_r;

  // Request decode
  func_t            func;
  logic             accept;
  logic             is_tick, is_press, is_read;
  logic [CNT_W-1:0] press_gap;
  logic             press_ok;
  logic             lap_wr;
  logic             slot_in_range;
  lap_entry_t       lap_wdata;
  lap_entry_t       lap_rdata;

  assign func     = func_t'(in_func);
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_tick  = (func == FUNC_TICK);
  assign is_press = (func == FUNC_PRESS);
  assign is_read  = (func == FUNC_READ);

  // Debounce: wrapping distance since the last accepted press
  assign press_gap = free_ms_r - last_press_r;
  assign press_ok  = press_gap >= {{(CNT_W-DBC_W){1'b0}}, debounce_r};
  assign lap_wr    = accept && is_press && press_ok && running_r;

  assign slot_in_range = 32'(in_slot) < 32'(LAP_SLOTS);

  assign lap_wdata.minutes = min_r;
  assign lap_wdata.seconds = sec_r;
  assign lap_wdata.millis  = ms_r;

  // Next-state logic for ticks and presses
  always_comb begin
    free_ms_nxt    = free_ms_r;
    prescale_nxt   = prescale_r;
    tenth_nxt      = tenth_r;
    ms_nxt         = ms_r;
    sec_nxt        = sec_r;
    min_nxt        = min_r;
    running_nxt    = running_r;
    last_press_nxt = last_press_r;
    wslot_nxt      = wslot_r;
    lap_total_nxt  = lap_total_r;
    if (is_tick) begin
      // free-running millisecond base
      if (prescale_r == TICK_TOP) begin
        prescale_nxt = '0;
        free_ms_nxt  = free_ms_r + 1'b1;
      end else begin
        prescale_nxt = prescale_r + 1'b1;
      end
      // sub-second count kept as millis and tenths
      if (running_r) begin
        if (tenth_r == TICK_TOP) begin
          tenth_nxt = '0;
          if (ms_r == MS_TOP) begin
            ms_nxt = '0;
            if (sec_r == SEC_TOP) begin
              sec_nxt = '0;
              min_nxt = min_r + 1'b1;
            end else begin
              sec_nxt = sec_r + 1'b1;
            end
          end else begin
            ms_nxt = ms_r + 1'b1;
          end
        end else begin
          tenth_nxt = tenth_r + 1'b1;
        end
      end
    end else if (is_press && press_ok) begin
      last_press_nxt = free_ms_r;
      if (!running_r) begin
        running_nxt = 1'b1;
      end else begin
        lap_total_nxt = lap_total_r + 1'b1;
        if (32'(wslot_r) == 32'(LAP_SLOTS - 1)) begin
          wslot_nxt = '0;
        end else begin
          wslot_nxt = wslot_r + AW'(1);
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      free_ms_r    <= '0;
      prescale_r   <= '0;
      tenth_r      <= '0;
      ms_r         <= '0;
      sec_r        <= '0;
      min_r        <= '0;
      running_r    <= 1'b0;
      last_press_r <= '0;
      wslot_r      <= '0;
      lap_total_r  <= '0;
    end else begin
      if (cfg_we) begin
        debounce_r <= cfg_wdata;
      end
      if (accept) begin
        free_ms_r    <= free_ms_nxt;
        prescale_r   <= prescale_nxt;
        tenth_r      <= tenth_nxt;
        ms_r         <= ms_nxt;
        sec_r        <= sec_nxt;
        min_r        <= min_nxt;
        running_r    <= running_nxt;
        last_press_r <= last_press_nxt;
        wslot_r      <= wslot_nxt;
        lap_total_r  <= lap_total_nxt;
      end
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: status after the request
  always_ff @(posedge clk) begin
    if (accept) begin
      out_stored_r      <= lap_wr;
      out_stored_slot_r <= lap_wr ? SLOT_W'(wslot_r) : '0;
    end
  end

  // Lap ring storage; its read register is part of the result stage
  swlm_lap_mem #(
    .LAP_SLOTS (LAP_SLOTS),
    .AW        (AW)
  ) u_lap_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (lap_wr),
    .wr_addr (wslot_r),
    .wr_data (lap_wdata),
    .rd_en   (accept),
    .rd_req  (is_read && slot_in_range),
    .rd_addr (AW'(in_slot)),
    .rd_data (lap_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_running      = running_r;
  assign out_minutes_now  = min_r;
  assign out_seconds_now  = sec_r;
  assign out_millis_now   = ms_r;
  assign out_lap_stored   = out_stored_r;
  assign out_stored_slot  = out_stored_slot_r;
  assign out_lap_total    = lap_total_r;
  assign out_next_slot    = SLOT_W'(wslot_r);
  assign out_read_minutes = lap_rdata.minutes;
  assign out_read_seconds = lap_rdata.seconds;
  assign out_read_millis  = lap_rdata.millis;

  // Checks
  a_lap_needs_running: assert property (@(posedge clk) disable iff (!rst_n)
    lap_wr |-> running_r)
    else $error("lap stored while stopwatch not running");

  a_running_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(running_r))
    else $error("running flag dropped without reset");

  a_subsec_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (ms_r <= MS_TOP) && (tenth_r <= TICK_TOP) && (sec_r <= SEC_TOP))
    else $error("time counter out of range");

  a_lap_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    lap_wr |=> (lap_total_r == $past(lap_total_r) + 1'b1))
    else $error("lap total did not advance on stored lap");

endmodule

// ===== bench/swlm_result_check.sv =====
// Result checker for the stopwatch: mirrors the counters and lap ring and compares every result.
module swlm_result_check
  import swlm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_running,
  input  logic [MIN_W-1:0]  out_minutes_now,
  input  logic [SEC_W-1:0]  out_seconds_now,
  input  logic [MS_W-1:0]   out_millis_now,
  input  logic              out_lap_stored,
  input  logic [SLOT_W-1:0] out_stored_slot,
  input  logic [TOT_W-1:0]  out_lap_total,
  input  logic [SLOT_W-1:0] out_next_slot,
  input  logic [MIN_W-1:0]  out_read_minutes,
  input  logic [SEC_W-1:0]  out_read_seconds,
  input  logic [MS_W-1:0]   out_read_millis,
  input  logic              cfg_we,
  input  logic [DBC_W-1:0]  cfg_wdata,
  input  logic              drain_done,
  output int                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              SUB_W        = 14;
  localparam logic [SUB_W-1:0] SUBSEC_TOP  = 14'd9999;
  localparam int              TICKS_PER_MS = 10;
  localparam int              MAX_SHOWN    = 40;

  // What one result carries, in port order
  typedef struct packed {
    logic              running;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic [MS_W-1:0]   millis;
    logic              lap_stored;
    logic [SLOT_W-1:0] stored_slot;
    logic [TOT_W-1:0]  lap_total;
    logic [SLOT_W-1:0] next_slot;
    lap_entry_t        readback;
  } status_t;

  // Mirrored stopwatch state
  logic [DBC_W-1:0]  debounce_win;
  logic [PRE_W-1:0]  tick_div;
  logic [CNT_W-1:0]  ms_clock;
  logic [CNT_W-1:0]  last_press;
  logic [SUB_W-1:0]  subsec;
  logic [SEC_W-1:0]  secs;
  logic [MIN_W-1:0]  mins;
  logic              started;
  logic [SLOT_W-1:0] ring_wr;
  logic [TOT_W-1:0]  lap_count;
  lap_entry_t        lap_ring [LAP_SLOTS_DEF];

  // Expected results, oldest first
  status_t expected_status [$];
  bit      leftovers_checked = 1'b0;

  initial fail_count = 0;

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic clear_stopwatch();
    debounce_win = DEBOUNCE_RST;
    tick_div     = '0;
    ms_clock     = '0;
    last_press   = '0;
    subsec       = '0;
    secs         = '0;
    mins         = '0;
    started      = 1'b0;
    ring_wr      = '0;
    lap_count    = '0;
    foreach (lap_ring[i]) lap_ring[i] = '0;
    expected_status.delete();
  endtask

  // Apply one request to the mirrored state and return the status it produces
  function automatic status_t step_stopwatch(input logic [FUNC_W-1:0] f,
                                             input logic [SLOT_W-1:0] s);
    status_t          r;
    logic [CNT_W-1:0] elapsed;
    r       = '0;
    elapsed = ms_clock - last_press;
    case (f)
      FUNC_TICK: begin
        // ms clock runs always, stopwatch only once started
        if (tick_div == TICK_TOP) begin
          tick_div = '0;
          ms_clock = ms_clock + 1'b1;
        end else begin
          tick_div = tick_div + 1'b1;
        end
        if (started) begin
          if (subsec == SUBSEC_TOP) begin
            subsec = '0;
            if (secs == SEC_TOP) begin
              secs = '0;
              mins = mins + 1'b1;
            end else begin
              secs = secs + 1'b1;
            end
          end else begin
            subsec = subsec + 1'b1;
          end
        end
      end
      FUNC_PRESS: begin
        // bounced presses leave everything alone, last press time included
        if (elapsed >= debounce_win) begin
          last_press = ms_clock;
          if (!started) begin
            started = 1'b1;
          end else begin
            lap_ring[ring_wr] = {mins, secs, MS_W'(subsec / TICKS_PER_MS)};
            r.lap_stored      = 1'b1;
            r.stored_slot     = ring_wr;
            ring_wr           = SLOT_W'((ring_wr + 1) % LAP_SLOTS_DEF);
            lap_count         = lap_count + 1'b1;
          end
        end
      end
      FUNC_READ: begin
        if (s < LAP_SLOTS_DEF) r.readback = lap_ring[s];
      end
      default: ;
    endcase
    r.running   = started;
    r.minutes   = mins;
    r.seconds   = secs;
    r.millis    = MS_W'(subsec / TICKS_PER_MS);
    r.lap_total = lap_count;
    r.next_slot = ring_wr;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic compare_status(input status_t want);
    check_field("running",      out_running,      want.running);
    check_field("minutes_now",  out_minutes_now,  want.minutes);
    check_field("seconds_now",  out_seconds_now,  want.seconds);
    check_field("millis_now",   out_millis_now,   want.millis);
    check_field("lap_stored",   out_lap_stored,   want.lap_stored);
    check_field("stored_slot",  out_stored_slot,  want.stored_slot);
    check_field("lap_total",    out_lap_total,    want.lap_total);
    check_field("next_slot",    out_next_slot,    want.next_slot);
    check_field("read_minutes", out_read_minutes, want.readback.minutes);
    check_field("read_seconds", out_read_seconds, want.readback.seconds);
    check_field("read_millis",  out_read_millis,  want.readback.millis);
  endtask

  // Sample both channels and the register port at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stopwatch();
    end else begin
      if (cfg_we) debounce_win = cfg_wdata;
      if (in_valid && !in_stall) expected_status.push_back(step_stopwatch(in_func, in_slot));
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) report("result with no request pending");
        else compare_status(expected_status.pop_front());
      end
      if (drain_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_status.size() != 0)
          report($sformatf("%0d results never arrived", expected_status.size()));
      end
    end
  end

endmodule

// ===== bench/tb_stopwatch_with_lap_memory_unit.sv =====
// Testbench top for the stopwatch with lap memory: clock, reset, request and result traffic.
module tb_stopwatch_with_lap_memory_unit
  import swlm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                CLK_PERIOD  = 10;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int                HOLD_OFF    = 120;
  localparam int                CYCLE_LIMIT = 250_000;
  localparam int                BURST_TICKS = 240;
  localparam int                LAP_EVERY   = 24;
  localparam int                PHASE_ITEMS = 240;

  logic              clk   = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func = FUNC_TICK;
  logic [SLOT_W-1:0] in_slot = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_running;
  logic [MIN_W-1:0]  out_minutes_now;
  logic [SEC_W-1:0]  out_seconds_now;
  logic [MS_W-1:0]   out_millis_now;
  logic              out_lap_stored;
  logic [SLOT_W-1:0] out_stored_slot;
  logic [TOT_W-1:0]  out_lap_total;
  logic [SLOT_W-1:0] out_next_slot;
  logic [MIN_W-1:0]  out_read_minutes;
  logic [SEC_W-1:0]  out_read_seconds;
  logic [MS_W-1:0]   out_read_millis;
  logic              cfg_we = 1'b0;
  logic [DBC_W-1:0]  cfg_wdata = '0;
  logic              drain_done = 1'b0;
  int                fail_count;

  int requests_sent = 0;
  int results_taken = 0;
  int cycles        = 0;
  bit quiet         = 1'b0;   // no idling on either side while set

  stopwatch_with_lap_memory_unit uut (.*);

  swlm_result_check lap_check (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run-away guard
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("stopwatch_with_lap_memory_unit test failed");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic issue(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_slot  <= s;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Stop offering and wait for every result to come back
  task automatic settle();
    in_valid <= 1'b0;
    while (results_taken != requests_sent) @(posedge clk);
  endtask

  task automatic set_debounce(input logic [DBC_W-1:0] win);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: random stalls, now and then a long hold-off to back up the block
  initial begin : result_sink
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (!quiet && results_taken % 300 == 150) gap = HOLD_OFF;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  initial begin : stimulus
    logic [DBC_W-1:0]  windows [4];
    logic [FUNC_W-1:0] f;
    int                pick;
    int                i;
    windows = '{16'hFFFF, 16'd1, 16'd0, 16'd4};
    windows[3] = DBC_W'($urandom_range(2, 12));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Stopped, default window: unused code, empty slots, presses bounce at time zero
    issue(FUNC_UNUSED, 3'd7);
    issue(FUNC_READ, 3'd0);
    issue(FUNC_READ, 3'd7);
    issue(FUNC_PRESS, 3'd0);
    repeat (3) issue(FUNC_TICK, 3'd5);
    issue(FUNC_PRESS, 3'd2);

    // Zero window: start, a lap at zero time, a lap after a few ticks
    set_debounce('0);
    issue(FUNC_PRESS, 3'd1);
    issue(FUNC_PRESS, 3'd6);
    for (i = 0; i < 10; i++) issue(FUNC_TICK, SLOT_W'(i));
    issue(FUNC_PRESS, 3'd3);
    issue(FUNC_READ, 3'd0);
    issue(FUNC_READ, 3'd1);
    issue(FUNC_UNUSED, 3'd0);

    // Back-to-back ticks with a lap every few dozen, enough laps to wrap the ring
    quiet = 1'b1;
    for (i = 1; i <= BURST_TICKS; i++) begin
      issue(FUNC_TICK, SLOT_W'($urandom));
      if (i % LAP_EVERY == 0) issue(FUNC_PRESS, SLOT_W'($urandom));
    end
    for (i = 0; i < LAP_SLOTS_DEF; i++) issue(FUNC_READ, SLOT_W'(i));
    quiet = 1'b0;

    // Random traffic under several windows, widest first
    foreach (windows[p]) begin
      set_debounce(windows[p]);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p >= 2 && i % 50 == 0) quiet = $urandom_range(0, 1);
        pick = $urandom_range(0, 99);
        f = (pick < 62) ? FUNC_TICK :
            (pick < 80) ? FUNC_PRESS :
            (pick < 94) ? FUNC_READ : FUNC_UNUSED;
        issue(f, SLOT_W'($urandom_range(0, 7)));
      end
      quiet = 1'b0;
    end

    settle();
    repeat (4) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("stopwatch_with_lap_memory_unit test passed");
    end else begin
      $display("stopwatch_with_lap_memory_unit test failed");
    end
    $finish;
  end

endmodule
